FILE: rtl/lhq_pkg.sv
// Shared types, codes and command/status bundles for the line hull query block.
package lhq_pkg;

  // One input item.
  typedef struct packed {
    logic               func;
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic signed [31:0] query_x;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic signed [63:0] value;
    logic [2:0]         status;
  } out_item_t;

  // One stored line, possibly negated (33 bits each).
  typedef struct packed {
    logic signed [32:0] a;
    logic signed [32:0] b;
  } line_t;

  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_ADDED   = 3'd1,
    ST_DROPPED = 3'd2,
    ST_FULL    = 3'd3,
    ST_EMPTY   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PH_NEW,
    PH_RIGHT,
    PH_LEFT
  } phase_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_NEW_L,
    S_NEW_LW,
    S_NEW_RW,
    S_T1,
    S_T2,
    S_T3,
    S_RP_A,
    S_RP_B,
    S_RP_C,
    S_LP_A,
    S_LP_B,
    S_LP_C,
    S_FIN,
    S_CP_RD,
    S_CP_WR,
    S_Q0,
    S_Q0W,
    S_Q_A,
    S_Q_B,
    S_QT1,
    S_QT2,
    S_QT3,
    S_QV1,
    S_QV2,
    S_DONE
  } state_e;

  // Controller to datapath.
  typedef struct packed {
    logic    load_in;
    logic    ld_l_rd;
    logic    ld_l_new;
    logic    ld_m_rd;
    logic    ld_m_new;
    logic    ld_r_rd;
    logic    ld_r_new;
    logic    has_l;
    logic    has_r;
    logic    shift_lr;
    logic    wr_en;
    logic    wr_new;
    logic    swap;
    logic    set_res;
    logic    res_val;
    status_e res_code;
    logic    publish;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic query_item;
    logic rd_gt_new;
    logic redundant;
    logic q_advance;
    logic slot_free;
  } stat_t;

endpackage

FILE: rtl/lhq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lhq_ram #(
  parameter int unsigned WIDTH = 66,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/lhq_ctrl.sv
// Sequencer for insert, prune, copy and query walks over the line table.
module lhq_ctrl import lhq_pkg::*; #(
  parameter int unsigned MAX_LINES = 64,
  localparam int unsigned AW = $clog2(MAX_LINES),
  localparam int unsigned CW = $clog2(MAX_LINES + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  stat_t         stat_i,
  output cmd_t          cmd_o,
  output logic [AW-1:0] raddr_o,
  output logic [AW-1:0] waddr_o
);

  state_e        state_q, state_d;
  phase_e        phase_q, phase_d;
  logic [CW-1:0] k_q, k_d;
  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] r_q, r_d;
  logic [CW-1:0] l_q, l_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW:0]   nc_q, nc_d;
  logic [CW:0]   nc_sum;
  logic          nc_over;
  logic [CW-1:0] src;

  // Size of the table after keeping old[0..l-1], the new line and old[r..n-1].
  assign nc_sum  = (CW+1)'(l_q) + (CW+1)'(count_q) + (CW+1)'(1) - (CW+1)'(r_q);
  assign nc_over = nc_sum > (CW+1)'(MAX_LINES);
  assign src     = (k_q < l_q) ? k_q : (k_q + r_q - l_q - CW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_NEW;
      k_q     <= '0;
      pos_q   <= '0;
      r_q     <= '0;
      l_q     <= '0;
      count_q <= '0;
      nc_q    <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      k_q     <= k_d;
      pos_q   <= pos_d;
      r_q     <= r_d;
      l_q     <= l_d;
      count_q <= count_d;
      nc_q    <= nc_d;
    end
  end

  // Next state and counters.
  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    k_d     = k_q;
    pos_d   = pos_q;
    r_d     = r_q;
    l_d     = l_q;
    count_d = count_q;
    nc_d    = nc_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          k_d = '0;
          if (stat_i.query_item) begin
            state_d = (count_q == '0) ? S_DONE : S_Q0;
          end else if (count_q == '0) begin
            pos_d   = '0;
            state_d = S_NEW_L;
          end else begin
            state_d = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: state_d = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (stat_i.rd_gt_new) begin
          pos_d   = k_q;
          state_d = S_NEW_L;
        end else if (k_q + CW'(1) == count_q) begin
          pos_d   = count_q;
          state_d = S_NEW_L;
        end else begin
          k_d     = k_q + CW'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_NEW_L:  state_d = S_NEW_LW;
      S_NEW_LW: state_d = S_NEW_RW;
      S_NEW_RW: begin
        phase_d = PH_NEW;
        state_d = S_T1;
      end
      S_T1: state_d = S_T2;
      S_T2: state_d = S_T3;
      S_T3: begin
        case (phase_q)
          PH_NEW: begin
            if (stat_i.redundant) begin
              state_d = S_DONE;
            end else begin
              r_d     = pos_q;
              state_d = S_RP_A;
            end
          end
          PH_RIGHT: begin
            if (stat_i.redundant) begin
              r_d     = r_q + CW'(1);
              state_d = S_RP_A;
            end else begin
              l_d     = pos_q;
              state_d = S_LP_A;
            end
          end
          PH_LEFT: begin
            if (stat_i.redundant) begin
              l_d     = l_q - CW'(1);
              state_d = S_LP_A;
            end else begin
              state_d = S_FIN;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_RP_A: begin
        if (r_q == count_q) begin
          l_d     = pos_q;
          state_d = S_LP_A;
        end else begin
          state_d = S_RP_B;
        end
      end
      S_RP_B: state_d = S_RP_C;
      S_RP_C: begin
        phase_d = PH_RIGHT;
        state_d = S_T1;
      end
      S_LP_A: state_d = (l_q == '0) ? S_FIN : S_LP_B;
      S_LP_B: state_d = S_LP_C;
      S_LP_C: begin
        phase_d = PH_LEFT;
        state_d = S_T1;
      end
      S_FIN: begin
        nc_d    = nc_sum;
        k_d     = '0;
        state_d = nc_over ? S_DONE : S_CP_RD;
      end
      S_CP_RD: begin
        if ((CW+1)'(k_q) == nc_q) begin
          count_d = nc_q[CW-1:0];
          state_d = S_DONE;
        end else if (k_q == l_q) begin
          k_d = k_q + CW'(1);
        end else begin
          state_d = S_CP_WR;
        end
      end
      S_CP_WR: begin
        k_d     = k_q + CW'(1);
        state_d = S_CP_RD;
      end
      S_Q0:  state_d = S_Q0W;
      S_Q0W: state_d = S_Q_A;
      S_Q_A: state_d = (k_q + CW'(1) == count_q) ? S_QV1 : S_Q_B;
      S_Q_B: state_d = S_QT1;
      S_QT1: state_d = S_QT2;
      S_QT2: state_d = S_QT3;
      S_QT3: begin
        if (stat_i.q_advance) begin
          k_d     = k_q + CW'(1);
          state_d = S_Q_A;
        end else begin
          state_d = S_QV1;
        end
      end
      S_QV1: state_d = S_QV2;
      S_QV2: state_d = S_DONE;
      S_DONE: begin
        if (stat_i.slot_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands and addresses.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    raddr_o    = '0;
    waddr_o    = k_q[AW-1:0];
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.load_in = in_valid_i;
        if (in_valid_i && stat_i.query_item && count_q == '0) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = ST_EMPTY;
        end
      end
      S_SCAN_RD: raddr_o = k_q[AW-1:0];
      S_NEW_L:   raddr_o = AW'(pos_q - CW'(1));
      S_NEW_LW: begin
        cmd_o.ld_l_rd = 1'b1;
        cmd_o.has_l   = pos_q != '0;
        raddr_o       = pos_q[AW-1:0];
      end
      S_NEW_RW: begin
        cmd_o.ld_r_rd  = 1'b1;
        cmd_o.has_r    = pos_q != count_q;
        cmd_o.ld_m_new = 1'b1;
      end
      S_T3: begin
        if (phase_q == PH_NEW && stat_i.redundant) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = ST_DROPPED;
        end
      end
      S_RP_A: raddr_o = r_q[AW-1:0];
      S_RP_B: begin
        cmd_o.ld_m_rd = 1'b1;
        raddr_o       = AW'(r_q + CW'(1));
      end
      S_RP_C: begin
        cmd_o.ld_r_rd  = 1'b1;
        cmd_o.has_r    = (r_q + CW'(1)) != count_q;
        cmd_o.ld_l_new = 1'b1;
        cmd_o.has_l    = 1'b1;
      end
      S_LP_A: raddr_o = AW'(l_q - CW'(1));
      S_LP_B: begin
        cmd_o.ld_m_rd = 1'b1;
        raddr_o       = AW'(l_q - CW'(2));
      end
      S_LP_C: begin
        cmd_o.ld_l_rd  = 1'b1;
        cmd_o.has_l    = l_q >= CW'(2);
        cmd_o.ld_r_new = 1'b1;
        cmd_o.has_r    = 1'b1;
      end
      S_FIN: begin
        if (nc_over) begin
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = ST_FULL;
        end
      end
      S_CP_RD: begin
        if ((CW+1)'(k_q) == nc_q) begin
          cmd_o.swap     = 1'b1;
          cmd_o.set_res  = 1'b1;
          cmd_o.res_code = ST_ADDED;
        end else if (k_q == l_q) begin
          cmd_o.wr_en  = 1'b1;
          cmd_o.wr_new = 1'b1;
        end else begin
          raddr_o = src[AW-1:0];
        end
      end
      S_CP_WR: cmd_o.wr_en = 1'b1;
      S_Q0:    raddr_o = '0;
      S_Q0W: begin
        cmd_o.ld_l_rd = 1'b1;
        cmd_o.has_l   = 1'b1;
      end
      S_Q_A: raddr_o = AW'(k_q + CW'(1));
      S_Q_B: begin
        cmd_o.ld_r_rd = 1'b1;
        cmd_o.has_r   = 1'b1;
      end
      S_QT3: cmd_o.shift_lr = stat_i.q_advance;
      S_QV2: begin
        cmd_o.set_res  = 1'b1;
        cmd_o.res_val  = 1'b1;
        cmd_o.res_code = ST_OK;
      end
      S_DONE: cmd_o.publish = stat_i.slot_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

FILE: rtl/lhq_dp.sv
// Datapath: two table banks, line registers, wide product tests and result slot.
module lhq_dp import lhq_pkg::*; #(
  parameter int unsigned MAX_LINES = 64,
  localparam int unsigned AW = $clog2(MAX_LINES)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  in_item_t      in_item_i,
  input  logic          cfg_valid_i,
  input  logic          cfg_data_i,
  input  cmd_t          cmd_i,
  input  logic [AW-1:0] raddr_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          out_ready_i,
  output stat_t         stat_o,
  output logic          out_valid_o,
  output out_item_t     out_item_o
);

  logic               find_min_q;
  logic               bank_q;
  line_t              n_q, l_q, m_q, r_q;
  logic               has_l_q, has_r_q;
  logic signed [31:0] x_q;
  line_t              rd0, rd1, rd, wdata;
  logic signed [32:0] in_a, in_b;

  logic signed [33:0] d1_q, d2_q, d3_q, d4_q, qa_q, qb_q;
  logic signed [67:0] p1_q, p2_q;
  logic signed [65:0] qp_q;
  logic signed [63:0] pv_q, vsum, vres;

  logic [63:0]        pend_value_q;
  status_e            pend_status_q;
  logic               out_valid_q;
  out_item_t          out_item_q;

  // Two banks: read the live one, build the next table in the other.
  assign rd    = bank_q ? rd1 : rd0;
  assign wdata = cmd_i.wr_new ? n_q : rd;

  lhq_ram #(.WIDTH($bits(line_t)), .DEPTH(MAX_LINES)) u_bank0 (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en & bank_q),
    .waddr_i(waddr_i),
    .wdata_i(wdata),
    .raddr_i(raddr_i),
    .rdata_o(rd0)
  );

  lhq_ram #(.WIDTH($bits(line_t)), .DEPTH(MAX_LINES)) u_bank1 (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_en & ~bank_q),
    .waddr_i(waddr_i),
    .wdata_i(wdata),
    .raddr_i(raddr_i),
    .rdata_o(rd1)
  );

  assign in_a = find_min_q ? -$signed({in_item_i.slope[31], in_item_i.slope})
                           :  $signed({in_item_i.slope[31], in_item_i.slope});
  assign in_b = find_min_q ? -$signed({in_item_i.intercept[31], in_item_i.intercept})
                           :  $signed({in_item_i.intercept[31], in_item_i.intercept});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      find_min_q  <= 1'b1;
      bank_q      <= 1'b0;
      has_l_q     <= 1'b0;
      has_r_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        find_min_q <= cfg_data_i;
      end
      if (cmd_i.swap) begin
        bank_q <= ~bank_q;
      end
      if (cmd_i.ld_l_rd || cmd_i.ld_l_new) begin
        has_l_q <= cmd_i.has_l;
      end
      if (cmd_i.ld_r_rd || cmd_i.ld_r_new) begin
        has_r_q <= cmd_i.has_r;
      end
      if (cmd_i.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      n_q.a <= in_a;
      n_q.b <= in_b;
      x_q   <= in_item_i.query_x;
    end
    if (cmd_i.ld_l_rd) begin
      l_q <= rd;
    end else if (cmd_i.ld_l_new) begin
      l_q <= n_q;
    end else if (cmd_i.shift_lr) begin
      l_q <= r_q;
    end
    if (cmd_i.ld_m_rd) begin
      m_q <= rd;
    end else if (cmd_i.ld_m_new) begin
      m_q <= n_q;
    end
    if (cmd_i.ld_r_rd) begin
      r_q <= rd;
    end else if (cmd_i.ld_r_new) begin
      r_q <= n_q;
    end

    // Free-running test pipeline: differences, then products.
    d1_q <= 34'($signed(l_q.b)) - 34'($signed(m_q.b));
    d2_q <= 34'($signed(r_q.a)) - 34'($signed(m_q.a));
    d3_q <= 34'($signed(r_q.b)) - 34'($signed(m_q.b));
    d4_q <= 34'($signed(l_q.a)) - 34'($signed(m_q.a));
    qa_q <= 34'($signed(r_q.a)) - 34'($signed(l_q.a));
    qb_q <= 34'($signed(l_q.b)) - 34'($signed(r_q.b));
    p1_q <= 68'(d1_q) * 68'(d2_q);
    p2_q <= 68'(d3_q) * 68'(d4_q);
    qp_q <= 66'(qa_q) * 66'(x_q);
    pv_q <= 64'($signed(l_q.a)) * 64'(x_q);

    if (cmd_i.set_res) begin
      pend_status_q <= cmd_i.res_code;
      pend_value_q  <= cmd_i.res_val ? vres : 64'd0;
    end
    if (cmd_i.publish) begin
      out_item_q.value  <= pend_value_q;
      out_item_q.status <= pend_status_q;
    end
  end

  assign vsum = pv_q + 64'($signed(l_q.b));
  assign vres = find_min_q ? -vsum : vsum;

  always_comb begin
    stat_o            = '0;
    stat_o.query_item = in_item_i.func == FUNC_QUERY;
    stat_o.rd_gt_new  = $signed(rd.a) > $signed(n_q.a);
    stat_o.q_advance  = qp_q > 66'(qb_q);
    stat_o.slot_free  = ~out_valid_q | out_ready_i;
    if (!has_l_q) begin
      stat_o.redundant = has_r_q && (m_q.a == r_q.a) && ($signed(m_q.b) <= $signed(r_q.b));
    end else if (!has_r_q) begin
      stat_o.redundant = (m_q.a == l_q.a) && ($signed(m_q.b) <= $signed(l_q.b));
    end else begin
      stat_o.redundant = p1_q >= p2_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

FILE: rtl/line_hull_max_query.sv
// Top level of the line hull container: controller, datapath and checks.
//
// Keeps the upper envelope of lines y = a*x + b sorted by slope, in a table
// of MAX_LINES entries held in two RAM banks (one live, one being rebuilt).
// Input channel (in_valid_i / in_ready_o, item in_item_i): func 0 adds a
// line, func 1 queries the best value at query_x. Every item yields exactly
// one result item on out_valid_o / out_ready_i (out_item_o: value, status).
// Config channel (cfg_valid_i / cfg_ready_o, cfg_data_i) sets find_minimum;
// it is always ready and is meant to be written while the block is idle.
// One item is in work at a time. An add scans for its slot, tests the new
// line, prunes neighbors to the right and then to the left, and copies the
// kept lines and the new one into the other bank; a refused or dropped add
// skips the copy. A query walks the table from line 0 until a test stops
// the walk or the last line is reached; an empty table answers with no
// walk. The pace is set by the live bank's single read port, walked one
// line at a time, and by the difference/product/compare test.
// Reset empties the table (count zero, no clearing pass) and sets
// find_minimum to 1. A finished result waits in an output register; the
// next item is taken meanwhile, and its result holds until the slot frees.
module line_hull_max_query import lhq_pkg::*; #(
  parameter int unsigned MAX_LINES = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_LINES);

  cmd_t          cmd;
  stat_t         stat;
  logic [AW-1:0] raddr, waddr;

  // The config channel is always ready.
  assign cfg_ready_o = 1'b1;

  lhq_ctrl #(.MAX_LINES(MAX_LINES)) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .raddr_o   (raddr),
    .waddr_o   (waddr)
  );

  lhq_dp #(.MAX_LINES(MAX_LINES)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .raddr_i    (raddr),
    .waddr_i    (waddr),
    .out_ready_i(out_ready_i),
    .stat_o     (stat),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o)
  );

  // One item in work: an accepted item holds ready low in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice in a row");

  // Only a successful query carries a nonzero value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != ST_OK |-> out_item_o.value == 64'd0)
    else $error("nonzero value on a non-query status");

  // A result is published only from a pending item, never while idle-ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.publish |-> !in_ready_o)
    else $error("result published while idle");

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the line hull max/min query block.
`timescale 1ns / 1ps

module testbench import lhq_pkg::*; ();

  localparam int unsigned DEPTH = 64;
  localparam int unsigned CYCLE_LIMIT = 10000000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;
  logic      cfg_valid_i;
  logic      cfg_ready_o;
  logic      cfg_data_i;

  line_hull_max_query #(.MAX_LINES(DEPTH)) uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .out_valid_o, .out_ready_i, .out_item_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  // Envelope copy kept in step with the block; 33-bit values held in 64-bit ints.
  longint    hull_a[$];
  longint    hull_b[$];
  bit        want_min;
  out_item_t answers_due[$];
  int        error_count;
  longint    cycle_count;
  int        hold_off_cycles;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Exact signed product; 34-bit operands fit easily into 128 bits.
  function automatic logic signed [127:0] wide_product(longint p, longint q);
    logic signed [127:0] wp;
    logic signed [127:0] wq;
    wp = p;
    wq = q;
    return wp * wq;
  endfunction

  // Is line i of the working list dominated by its neighbors?
  function automatic bit is_covered(ref longint wa[$], ref longint wb[$], input int i);
    bit next_ok;
    next_ok = (i + 1 < wa.size());
    if (i == 0) begin
      if (!next_ok) return 1'b0;
      return wa[0] == wa[1] && wb[0] <= wb[1];
    end
    if (!next_ok) return wa[i] == wa[i-1] && wb[i] <= wb[i-1];
    return wide_product(wb[i-1] - wb[i], wa[i+1] - wa[i]) >=
           wide_product(wb[i+1] - wb[i], wa[i-1] - wa[i]);
  endfunction

  // Work out the result of one item and advance the envelope copy.
  function automatic out_item_t hull_answer(in_item_t it);
    out_item_t r;
    longint wa[$];
    longint wb[$];
    longint a;
    longint b;
    longint x;
    int pos;
    int i;
    r.value = '0;
    if (it.func != FUNC_QUERY) begin
      a = it.slope;
      b = it.intercept;
      if (want_min) begin
        a = -a;
        b = -b;
      end
      wa = hull_a;
      wb = hull_b;
      pos = 0;
      while (pos < wa.size() && wa[pos] <= a) pos++;
      wa.insert(pos, a);
      wb.insert(pos, b);
      if (is_covered(wa, wb, pos)) begin
        r.status = ST_DROPPED;
        return r;
      end
      while (pos + 1 < wa.size() && is_covered(wa, wb, pos + 1)) begin
        wa.delete(pos + 1);
        wb.delete(pos + 1);
      end
      while (pos > 0 && is_covered(wa, wb, pos - 1)) begin
        wa.delete(pos - 1);
        wb.delete(pos - 1);
        pos--;
      end
      if (wa.size() > DEPTH) begin
        r.status = ST_FULL;
        return r;
      end
      hull_a = wa;
      hull_b = wb;
      r.status = ST_ADDED;
    end else begin
      if (hull_a.size() == 0) begin
        r.status = ST_EMPTY;
        return r;
      end
      x = it.query_x;
      i = 0;
      while (i + 1 < hull_a.size() &&
             wide_product(hull_a[i+1] - hull_a[i], x) >
             128'(signed'(hull_b[i] - hull_b[i+1])))
        i++;
      r.value = hull_a[i] * x + hull_b[i];
      if (want_min) r.value = -r.value;
      r.status = ST_OK;
    end
    return r;
  endfunction

  // Gap of random length: mostly none or short, now and then long.
  function automatic int random_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // Offer one item, hold it until taken, and queue its expected result.
  task automatic send_item(in_item_t it, bit idle_gaps);
    int gap;
    gap = idle_gaps ? random_gap() : 0;
    @(negedge clk_i);
    repeat (gap) @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    answers_due.push_back(hull_answer(it));
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  function automatic in_item_t make_add(longint a, longint b);
    in_item_t it;
    it.func      = ~FUNC_QUERY;
    it.slope     = 32'(a);
    it.intercept = 32'(b);
    it.query_x   = $urandom;
    return it;
  endfunction

  function automatic in_item_t make_query(longint x);
    in_item_t it;
    it.func      = FUNC_QUERY;
    it.slope     = $urandom;
    it.intercept = $urandom;
    it.query_x   = 32'(x);
    return it;
  endfunction

  // Drain outstanding results, let the block settle, then write the register.
  task automatic set_mode(bit minimum);
    while (answers_due.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= minimum;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    want_min = minimum;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Empty table queries and extremes of every field, in both modes.
  task automatic test_directed();
    longint edges[4] = '{-2147483648, 2147483647, 0, -1};
    send_item(make_query(0), 1'b0);
    send_item(make_query(-2147483648), 1'b0);
    foreach (edges[k]) send_item(make_add(edges[k], edges[3-k]), 1'b0);
    send_item(make_add(5, 7), 1'b0);
    send_item(make_add(5, 3), 1'b0);     // covered by the stored lines: dropped
    send_item(make_add(5, 9), 1'b0);     // covered by the stored lines: dropped
    foreach (edges[k]) send_item(make_query(edges[k]), 1'b0);
    send_item(make_query(2147483647), 1'b0);
    set_mode(1'b0);                      // flip with lines stored
    send_item(make_add(3, 1), 1'b0);
    send_item(make_add(-2147483648, 2147483647), 1'b0);
    send_item(make_query(123456789), 1'b0);
    send_item(make_query(-2147483648), 1'b0);
  endtask

  // Fill the table with a run of lines that all stay on the minimum envelope
  // until adds are refused.
  task automatic test_full_table();
    longint k;
    for (k = 0; k < DEPTH + 6; k++)
      send_item(make_add(k * 1000 - 32000, (k - 32) * (k - 32) * 500), 1'b1);
    // A low line that prunes its neighbors on a full table, then a steep one, then queries.
    send_item(make_add(0, -2147483648), 1'b1);
    send_item(make_add(40000, 2147483647), 1'b1);
    repeat (6) send_item(make_query($urandom_range(80000) - 40000), 1'b1);
  endtask

  // Random phases: mostly adds and queries on small coordinates so the hull
  // grows deep, with full-range noise mixed in.
  task automatic test_random(int count);
    in_item_t it;
    int roll;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < 45)
        it = make_add($urandom_range(2000) - 1000, $urandom_range(200000) - 100000);
      else if (roll < 85)
        it = make_query($urandom_range(4000) - 2000);
      else begin
        it.func      = 1'($urandom);
        it.slope     = $urandom;
        it.intercept = $urandom;
        it.query_x   = $urandom;
      end
      send_item(it, 1'b1);
    end
  endtask

  // Receiver stalls long while the sender keeps offering.
  task automatic test_back_pressure();
    hold_off_cycles = 300;
    repeat (8) send_item(make_query($urandom_range(100)), 1'b0);
    repeat (8) send_item(make_add($urandom_range(50), $urandom_range(50)), 1'b0);
  endtask

  // Drive the ready side: random stalls, or a long hold-off when requested.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_off_cycles--;
      end else begin
        out_ready_i <= (random_gap() == 0);
      end
    end
  end

  // Compare each result against the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected result value=%0d status=%0d",
                 $realtime, out_item_o.value, out_item_o.status);
        error_count++;
      end else begin
        want = answers_due.pop_front();
        if (out_item_o.value !== want.value) begin
          $display("%0t: value mismatch expected %0d actual %0d",
                   $realtime, want.value, out_item_o.value);
          error_count++;
        end
        if (out_item_o.status !== want.status) begin
          $display("%0t: status mismatch expected %0d actual %0d",
                   $realtime, want.status, out_item_o.status);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if the block hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("line_hull_max_query regression: fail");
      $finish;
    end
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = 1'b0;
    want_min = 1'b1;
    error_count = 0;
    cycle_count = 0;
    hold_off_cycles = 0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    set_mode(1'b1);
    test_full_table();
    test_back_pressure();
    test_random(600);
    set_mode(1'b0);
    test_random(600);
    set_mode(1'b1);
    test_random(550);
    while (answers_due.size() != 0) @(negedge clk_i);
    repeat (400) @(negedge clk_i);
    if (error_count == 0) begin
      $display("line_hull_max_query regression: pass");
    end else begin
      $display("line_hull_max_query regression: fail");
    end
    $finish;
  end

endmodule
